// File: rtl/edre_pkg.sv
// ----------------------------------------------------------------------------
// edre_pkg
// Shared types and codes for the edit distance row engine.
// ----------------------------------------------------------------------------
package edre_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_FIRST   = 2'd0;
    localparam logic [1:0] CMD_SECOND  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Status codes carried in m_tuser
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FIRST_FULL  = 2'd1;
    localparam logic [1:0] ST_SECOND_FULL = 2'd2;
    localparam logic [1:0] ST_FIRST_LATE  = 2'd3;

    // Width of the distance field on the output bus
    localparam int DIST_W = 7;

    typedef enum logic {
        FSM_IDLE,
        FSM_RUN
    } fsm_state_t;

    // Per-cell control strobes
    typedef struct packed {
        logic clear;    // reload cost with the cell index, drop the char
        logic load;     // store a first-word char in this cell
    } cell_ctl_t;

endpackage

// File: rtl/edre_cell.sv
// ----------------------------------------------------------------------------
// edre_cell
// One column of the distance row: holds one first-word char and its cost,
// updates the cost as a row wave passes and hands the wave to its neighbor.
// ----------------------------------------------------------------------------
module edre_cell #(
    parameter int IDX = 1,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  edre_pkg::cell_ctl_t ctl,
    input  logic [7:0]        load_sym,
    input  logic              wave_in_valid,
    input  logic [7:0]        wave_in_sym,
    input  logic [CW-1:0]     wave_in_left,
    input  logic [CW-1:0]     wave_in_diag,
    output logic              wave_out_valid,
    output logic [7:0]        wave_out_sym,
    output logic [CW-1:0]     wave_out_left,
    output logic [CW-1:0]     wave_out_diag
);
    import edre_pkg::*;

    logic [CW-1:0] cost_reg;
    logic [CW-1:0] cost_next;
    logic          used_reg;
    logic [7:0]    char_reg;
    logic          wvalid_reg;
    logic [7:0]    wsym_reg;
    logic [CW-1:0] wleft_reg;
    logic [CW-1:0] wdiag_reg;

    logic [CW:0] up_inc;
    logic [CW:0] left_inc;
    logic [CW:0] diag_mis;
    logic [CW:0] min_ul;
    logic [CW:0] min_all;

    always_comb
    begin
        up_inc   = {1'b0, cost_reg} + 1'b1;
        left_inc = {1'b0, wave_in_left} + 1'b1;
        diag_mis = {1'b0, wave_in_diag} + {{CW{1'b0}}, (char_reg != wave_in_sym)};
        min_ul   = (up_inc < left_inc) ? up_inc : left_inc;
        min_all  = (diag_mis < min_ul) ? diag_mis : min_ul;
        // the row never holds a value above the capacity, so the top bit drops
        cost_next = min_all[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg   <= CW'(IDX);
            used_reg   <= 1'b0;
            wvalid_reg <= 1'b0;
        end
        else
        begin
            wvalid_reg <= wave_in_valid;
            if (ctl.clear)
            begin
                cost_reg <= CW'(IDX);
                used_reg <= 1'b0;
            end
            else if (ctl.load)
            begin
                used_reg <= 1'b1;
            end
            else if (wave_in_valid && used_reg)
            begin
                cost_reg <= cost_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            char_reg <= load_sym;
        end
        wsym_reg <= wave_in_sym;
        // an unused cell passes the left value through untouched
        wleft_reg <= used_reg ? cost_next : wave_in_left;
        wdiag_reg <= cost_reg;
    end

    assign wave_out_valid = wvalid_reg;
    assign wave_out_sym   = wsym_reg;
    assign wave_out_left  = wleft_reg;
    assign wave_out_diag  = wdiag_reg;

endmodule

// File: rtl/edit_distance_row_engine_core.sv
// ----------------------------------------------------------------------------
// edit_distance_row_engine_core
// Unit-cost Levenshtein distance engine built on a chain of row cells.
// ----------------------------------------------------------------------------
// Send beats on the slave side with the command in s_tuser and the char in
// s_tdata; each beat returns exactly one master beat with the distance between
// the first word and the second word so far, plus a status code. First-word
// appends, restarts, the unused command and every rejected append finish with
// no wave. An accepted second-word char launches a row wave via the launch
// register into a chain of MAX_LEN cells, one cell per cycle; its result is
// registered as the wave leaves the last cell, and no beat is taken while the
// wave runs. The result register lets the next beat be taken while a finished
// result still waits on m_tready, provided the result slot frees up in the
// same cycle. Restart reloads the whole row. Distances above 127 saturate.
// ----------------------------------------------------------------------------
module edit_distance_row_engine_core #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] distance, [7] zero
    output logic [1:0] m_tuser    // [1:0] status
);
    import edre_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = (CW > DIST_W) ? CW : DIST_W;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic [CW-1:0] first_len_reg;
    logic [CW-1:0] second_len_reg;
    logic [CW-1:0] dist_reg;
    logic [CW-1:0] dist_next;

    logic          out_valid_reg;
    logic [CW-1:0] out_dist_reg;
    logic [1:0]    out_status_reg;

    logic          accept;
    logic          first_ok;
    logic          second_ok;
    logic          launch;
    logic          done;
    logic [1:0]    status_now;

    // wave bus between cells; entry 0 is the launch point
    logic          wave_valid [MAX_LEN+1];
    logic [7:0]    wave_sym   [MAX_LEN+1];
    logic [CW-1:0] wave_left  [MAX_LEN+1];
    logic [CW-1:0] wave_diag  [MAX_LEN+1];

    logic          launch_reg;
    logic [7:0]    launch_sym_reg;
    logic [CW-1:0] launch_left_reg;
    logic [CW-1:0] launch_diag_reg;

    cell_ctl_t     cell_ctl [MAX_LEN];

    logic [SW-1:0] dist_wide;

    assign accept    = s_tvalid && s_tready;
    assign first_ok  = (second_len_reg == '0) && (first_len_reg != CW'(MAX_LEN));
    assign second_ok = (second_len_reg != CW'(MAX_LEN));
    assign launch    = accept && (s_tuser == CMD_SECOND) && second_ok;
    assign done      = wave_valid[MAX_LEN];

    // ---- state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (launch)
                begin
                    state_next = FSM_RUN;
                end
            end
            FSM_RUN:
            begin
                if (done)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // ---- state machine: outputs
    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            FSM_IDLE: s_tready = !out_valid_reg || m_tready;
            FSM_RUN:  s_tready = 1'b0;
            default:  s_tready = 1'b0;
        endcase
    end

    // ---- status and running distance for the accepted beat
    always_comb
    begin
        status_now = ST_OK;
        dist_next  = dist_reg;
        case (s_tuser)
            CMD_FIRST:
            begin
                if (second_len_reg != '0)
                begin
                    status_now = ST_FIRST_LATE;
                end
                else if (!first_ok)
                begin
                    status_now = ST_FIRST_FULL;
                end
                else
                begin
                    dist_next = first_len_reg + 1'b1;
                end
            end
            CMD_SECOND:
            begin
                if (!second_ok)
                begin
                    status_now = ST_SECOND_FULL;
                end
            end
            CMD_RESTART: dist_next = '0;
            default:     dist_next = dist_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dist_reg       <= '0;
            out_valid_reg  <= 1'b0;
            launch_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch;
            if (accept)
            begin
                if (s_tuser == CMD_RESTART)
                begin
                    first_len_reg  <= '0;
                    second_len_reg <= '0;
                end
                else if (s_tuser == CMD_FIRST && first_ok)
                begin
                    first_len_reg <= first_len_reg + 1'b1;
                end
                else if (launch)
                begin
                    second_len_reg <= second_len_reg + 1'b1;
                end
            end
            // a launched wave reports when it leaves the chain
            if (accept && !launch)
            begin
                dist_reg <= dist_next;
            end
            else if (done)
            begin
                dist_reg <= wave_left[MAX_LEN];
            end
            if ((accept && !launch) || done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload and wave launch data
    always_ff @(posedge clk)
    begin
        if (accept && !launch)
        begin
            out_dist_reg   <= dist_next;
            out_status_reg <= status_now;
        end
        else if (done)
        begin
            out_dist_reg   <= wave_left[MAX_LEN];
            out_status_reg <= ST_OK;
        end
        if (launch)
        begin
            // column zero of the row equals the second-word length
            launch_sym_reg  <= s_tdata;
            launch_left_reg <= second_len_reg + 1'b1;
            launch_diag_reg <= second_len_reg;
        end
    end

    assign wave_valid[0] = launch_reg;
    assign wave_sym[0]   = launch_sym_reg;
    assign wave_left[0]  = launch_left_reg;
    assign wave_diag[0]  = launch_diag_reg;

    // ---- chain of row cells
    for (genvar k = 1; k <= MAX_LEN; k++)
    begin : g_cell
        assign cell_ctl[k-1].clear = accept && (s_tuser == CMD_RESTART);
        assign cell_ctl[k-1].load  = accept && (s_tuser == CMD_FIRST) && first_ok
                                     && (first_len_reg == CW'(k - 1));

        edre_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (cell_ctl[k-1]),
            .load_sym       (s_tdata),
            .wave_in_valid  (wave_valid[k-1]),
            .wave_in_sym    (wave_sym[k-1]),
            .wave_in_left   (wave_left[k-1]),
            .wave_in_diag   (wave_diag[k-1]),
            .wave_out_valid (wave_valid[k]),
            .wave_out_sym   (wave_sym[k]),
            .wave_out_left  (wave_left[k]),
            .wave_out_diag  (wave_diag[k])
        );
    end

    // ---- output beat, saturate wide distances
    assign dist_wide = SW'(out_dist_reg);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, (dist_wide > SW'(127)) ? 7'd127 : dist_wide[DIST_W-1:0]};
    assign m_tuser   = out_status_reg;

endmodule
